>>> sv/dft_pkg.sv
// dft_pkg: shared types and constants for the deadband step fan trim block
// used by dft_update and deadband_step_fan_trim; no dependencies
`default_nettype none

package dft_pkg;

    localparam int SampleWidth = 16;
    localparam int TrimWidth   = 16;
    localparam int CountWidth  = 16;
    localparam int LevelWidth  = 15;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDatWidth = 16;

    // trim plus or minus a step, with room so nothing wraps
    localparam int WideWidth   = TrimWidth + 2;

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_ACTIVE   = 2'd1,
        MODE_FROZEN   = 2'd2,
        MODE_UNUSED   = 2'd3
    } dft_mode_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_TARGET_LEVEL    = 3'd0,
        REG_DEAD_ZONE       = 3'd1,
        REG_STEP_SIZE       = 3'd2,
        REG_HOLD_TICKS      = 3'd3,
        REG_TRIM_FLOOR      = 3'd4,
        REG_TRIM_CEILING    = 3'd5,
        REG_RUN_MODE        = 3'd6,
        REG_BAD_SAMPLE_CODE = 3'd7
    } dft_reg_idx_t;

    localparam logic signed [SampleWidth-1:0] BadSampleReset = 16'sh7FFF;

    typedef struct packed {
        logic        [LevelWidth-1:0]  target_level;
        logic        [LevelWidth-1:0]  dead_zone;
        logic        [LevelWidth-1:0]  step_size;
        logic        [CountWidth-1:0]  hold_ticks;
        logic signed [TrimWidth-1:0]   trim_floor;
        logic signed [TrimWidth-1:0]   trim_ceiling;
        dft_mode_t                     run_mode;
        logic signed [SampleWidth-1:0] bad_sample_code;
    } dft_cfg_t;

    typedef struct packed {
        logic signed [TrimWidth-1:0]  trim;
        logic        [CountWidth-1:0] count;
    } dft_state_t;

endpackage

`default_nettype wire

>>> sv/dft_update.sv
// dft_update: next trim and hold-off count for one sample
// depends on dft_pkg
`default_nettype none

module dft_update (
    input  wire dft_pkg::dft_cfg_t                         cfg,
    input  wire dft_pkg::dft_state_t                       cur,
    input  wire logic signed [dft_pkg::SampleWidth-1:0]    sample,
    output dft_pkg::dft_state_t                            nxt
);
    import dft_pkg::*;

    logic                         bad;
    logic signed [WideWidth-1:0]  sample_w;
    logic signed [WideWidth-1:0]  band_hi;
    logic signed [WideWidth-1:0]  band_lo;
    logic signed [WideWidth-1:0]  trim_w;
    logic signed [WideWidth-1:0]  step_w;
    logic signed [WideWidth-1:0]  floor_w;
    logic signed [WideWidth-1:0]  ceil_w;
    logic signed [WideWidth-1:0]  stepped;

    assign bad      = (sample == cfg.bad_sample_code);
    assign sample_w = WideWidth'(sample);
    assign band_hi  = $signed(WideWidth'({1'b0, cfg.target_level}))
                    + $signed(WideWidth'({1'b0, cfg.dead_zone}));
    assign band_lo  = $signed(WideWidth'({1'b0, cfg.target_level}))
                    - $signed(WideWidth'({1'b0, cfg.dead_zone}));
    assign trim_w   = WideWidth'(cur.trim);
    assign step_w   = $signed(WideWidth'({1'b0, cfg.step_size}));
    assign floor_w  = WideWidth'(cfg.trim_floor);
    assign ceil_w   = WideWidth'(cfg.trim_ceiling);

    always_comb
    begin
        stepped = trim_w;
        if (cur.count == '0)
        begin
            if (sample_w > band_hi)
                stepped = trim_w - step_w;
            else if (sample_w < band_lo)
                stepped = trim_w + step_w;
        end
    end

    always_comb
    begin
        nxt = cur;
        if (bad)
        begin
            nxt.trim = '0;
        end
        else
        begin
            unique case (cfg.run_mode)
                MODE_ACTIVE:
                begin
                    if (cur.count != '0)
                        nxt.count = cur.count - 1'b1;
                    else
                        nxt.count = cfg.hold_ticks;
                    // when the limits cross, a step below the floor takes the floor, any other the ceiling
                    if (stepped < floor_w)
                        nxt.trim = cfg.trim_floor;
                    else if (stepped > ceil_w)
                        nxt.trim = cfg.trim_ceiling;
                    else
                        nxt.trim = stepped[TrimWidth-1:0];
                end
                MODE_FROZEN:
                begin
                    nxt = cur;
                end
                default:
                begin
                    nxt.trim = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/deadband_step_fan_trim.sv
// deadband_step_fan_trim: top level, config registers, trim state and output stage
// depends on dft_pkg and dft_update
`default_nettype none

// Each sample request updates a signed fan-speed trim and a hold-off counter
// and yields one trim result, the trim after that sample. The update is a
// compare, add and clamp done in dft_update right at the input, and the state
// and result registers load on the same edge, so a new sample is taken every
// cycle while the result register is empty or being drained. The result shows
// in the cycle after the sample is accepted.
// Configuration is written through cfg_we/cfg_index/cfg_data and takes
// effect on the next sample; write it only while no sample is in flight.
module deadband_step_fan_trim (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // bits 15:0 sensor_sample
    input  wire [15:0]                           s_axis_tdata,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // bits 15:0 speed_trim
    output logic [15:0]                          m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    input  wire                                  cfg_we,
    input  wire [dft_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  wire [dft_pkg::CfgDatWidth-1:0]       cfg_data
);
    import dft_pkg::*;

    dft_cfg_t                   cfg_reg;
    dft_state_t                 state_reg;
    dft_state_t                 state_next;
    logic [TrimWidth-1:0]       out_data_reg;
    logic                       out_valid_reg;
    logic                       in_fire;
    logic signed [SampleWidth-1:0] sample;

    assign sample        = $signed(s_axis_tdata[SampleWidth-1:0]);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level    <= '0;
            cfg_reg.dead_zone       <= '0;
            cfg_reg.step_size       <= '0;
            cfg_reg.hold_ticks      <= '0;
            cfg_reg.trim_floor      <= '0;
            cfg_reg.trim_ceiling    <= '0;
            cfg_reg.run_mode        <= MODE_DISABLED;
            cfg_reg.bad_sample_code <= BadSampleReset;
        end
        else if (cfg_we)
        begin
            unique case (dft_reg_idx_t'(cfg_index))
                REG_TARGET_LEVEL:    cfg_reg.target_level    <= cfg_data[LevelWidth-1:0];
                REG_DEAD_ZONE:       cfg_reg.dead_zone       <= cfg_data[LevelWidth-1:0];
                REG_STEP_SIZE:       cfg_reg.step_size       <= cfg_data[LevelWidth-1:0];
                REG_HOLD_TICKS:      cfg_reg.hold_ticks      <= cfg_data[CountWidth-1:0];
                REG_TRIM_FLOOR:      cfg_reg.trim_floor      <= $signed(cfg_data[TrimWidth-1:0]);
                REG_TRIM_CEILING:    cfg_reg.trim_ceiling    <= $signed(cfg_data[TrimWidth-1:0]);
                REG_RUN_MODE:        cfg_reg.run_mode        <= dft_mode_t'(cfg_data[1:0]);
                REG_BAD_SAMPLE_CODE: cfg_reg.bad_sample_code <= $signed(cfg_data[SampleWidth-1:0]);
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    dft_update u_update (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .sample (sample),
        .nxt    (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with the new trim on every accepted request
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= state_next.trim;
    end

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_axis_tvalid && (m_axis_tdata == state_reg.trim))
        else $error("result does not match the updated trim");

    a_disabled_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (cfg_reg.run_mode == MODE_DISABLED) |=> state_reg.trim == '0)
        else $error("disabled mode left a nonzero trim");

    a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (cfg_reg.run_mode == MODE_FROZEN) && (sample != cfg_reg.bad_sample_code)
        |=> $stable(state_reg))
        else $error("frozen mode changed the state");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (cfg_reg.run_mode == MODE_ACTIVE) && (sample != cfg_reg.bad_sample_code)
        && (cfg_reg.trim_floor <= cfg_reg.trim_ceiling)
        |=> (state_reg.trim >= $past(cfg_reg.trim_floor))
            && (state_reg.trim <= $past(cfg_reg.trim_ceiling)))
        else $error("active trim outside its limits");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// tb: self-checking bench for deadband_step_fan_trim, directed then random sample requests
// depends on dft_pkg and the deadband_step_fan_trim rtl; needs nothing else
module tb;
    import dft_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 4;
    localparam int RandomPhases  = 8;
    localparam int PhaseSamples  = 125;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic [15:0]  s_axis_tdata  = '0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    wire  [15:0]  m_axis_tdata;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         cfg_we        = 1'b0;
    dft_reg_idx_t cfg_index     = REG_TARGET_LEVEL;
    logic [15:0]  cfg_data      = '0;

    // local copy of the register file and of the trim state
    int        level_set;
    int        band_half;
    int        trim_step;
    int        hold_reload;
    int        trim_lo;
    int        trim_hi;
    int        fault_code;
    dft_mode_t mode_set;
    int        trim_now;
    int        holdoff_left;

    logic [15:0]        sample_queue[$];
    logic signed [15:0] trim_expected[$];
    logic signed [15:0] trim_want;

    int send_gap     = 0;
    int recv_gap     = 0;
    bit steady_tail  = 1'b0;
    bit sample_taken = 1'b0;
    int idle_cycles  = 0;
    int error_count  = 0;

    deadband_step_fan_trim DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // trim after one sample; updates the local state
    function automatic logic signed [15:0] advance_trim(input logic signed [15:0] sample);
        int smp;
        int trim_next;
        smp = int'(sample);
        if (smp == fault_code || mode_set == MODE_DISABLED || mode_set == MODE_UNUSED)
            trim_now = 0;
        else if (mode_set == MODE_ACTIVE)
        begin
            trim_next = trim_now;
            if (holdoff_left != 0)
                holdoff_left = holdoff_left - 1;
            else
            begin
                holdoff_left = hold_reload;
                if (smp > level_set + band_half)
                    trim_next = trim_now - trim_step;
                else if (smp < level_set - band_half)
                    trim_next = trim_now + trim_step;
            end
            // when floor sits above ceiling, a value below the floor takes the floor, any other the ceiling
            if (trim_next < trim_lo)
                trim_next = trim_lo;
            else if (trim_next > trim_hi)
                trim_next = trim_hi;
            trim_now = trim_next;
        end
        return 16'(trim_now);
    endfunction

    function automatic void store_reg(input dft_reg_idx_t idx, input logic [15:0] value);
        case (idx)
            REG_TARGET_LEVEL:    level_set   = int'(value[14:0]);
            REG_DEAD_ZONE:       band_half   = int'(value[14:0]);
            REG_STEP_SIZE:       trim_step   = int'(value[14:0]);
            REG_HOLD_TICKS:      hold_reload = int'(value);
            REG_TRIM_FLOOR:      trim_lo     = int'($signed(value));
            REG_TRIM_CEILING:    trim_hi     = int'($signed(value));
            REG_RUN_MODE:        mode_set    = dft_mode_t'(value[1:0]);
            REG_BAD_SAMPLE_CODE: fault_code  = int'($signed(value));
            default: ;
        endcase
    endfunction

    task automatic write_reg(input dft_reg_idx_t idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(value);
        @(posedge clk);
        store_reg(idx, 16'(value));
    endtask

    // block is idle once every queued sample went in and every trim came back
    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_axis_tvalid || trim_expected.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic load_setup(input int tgt, input int dz, input int stp, input int hold,
                              input int lo, input int hi, input dft_mode_t mode,
                              input int bad);
        wait_drained();
        write_reg(REG_TARGET_LEVEL, tgt);
        write_reg(REG_DEAD_ZONE, dz);
        write_reg(REG_STEP_SIZE, stp);
        write_reg(REG_HOLD_TICKS, hold);
        write_reg(REG_TRIM_FLOOR, lo);
        write_reg(REG_TRIM_CEILING, hi);
        write_reg(REG_RUN_MODE, int'(mode));
        write_reg(REG_BAD_SAMPLE_CODE, bad);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // sample request driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || sample_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (sample_queue.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (!steady_tail && $urandom_range(0, 7) == 0)
            begin
                send_gap      <= $urandom_range(0, 3);
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                s_axis_tdata  <= sample_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // trim receiver stalls
    always @(negedge clk)
    begin
        if (recv_gap != 0)
        begin
            recv_gap      <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!steady_tail && $urandom_range(0, 6) == 0)
        begin
            recv_gap      <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // monitor: predict on each sample request, check each trim request
    always @(posedge clk)
    begin
        sample_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                trim_expected.push_back(advance_trim(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (trim_expected.size() == 0)
                begin
                    error_count = error_count + 1;
                    $display("%0t unexpected speed_trim: expected none actual %0d",
                             $time, $signed(m_axis_tdata));
                end
                else
                begin
                    trim_want = trim_expected.pop_front();
                    if (m_axis_tdata !== trim_want)
                    begin
                        error_count = error_count + 1;
                        $display("%0t speed_trim mismatch: expected %0d actual %0d",
                                 $time, trim_want, $signed(m_axis_tdata));
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                idle_cycles <= 0;
            else if (idle_cycles >= WatchdogLimit)
            begin
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int        phase;
        int        n;
        int        r;
        int        span;
        int        tgt;
        int        dz;
        int        stp;
        int        hold;
        int        lo;
        int        hi;
        int        bad;
        dft_mode_t mode;
        logic [15:0] smp;

        level_set    = 0;
        band_half    = 0;
        trim_step    = 0;
        hold_reload  = 0;
        trim_lo      = 0;
        trim_hi      = 0;
        mode_set     = MODE_DISABLED;
        fault_code   = int'(BadSampleReset);
        trim_now     = 0;
        holdoff_left = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: disabled, trim stays zero
        sample_queue.push_back(16'h0000);
        sample_queue.push_back(16'h8000);

        // step down to the floor, band edges, step up, fault sample
        load_setup(1000, 100, 300, 0, -800, 1000, MODE_ACTIVE, 32767);
        sample_queue.push_back(16'd2000);
        sample_queue.push_back(16'd2000);
        sample_queue.push_back(16'd2000);
        sample_queue.push_back(16'd1050);
        sample_queue.push_back(16'd900);
        sample_queue.push_back(16'd899);
        sample_queue.push_back(16'h8000);
        sample_queue.push_back(16'h7FFF);
        sample_queue.push_back(16'd1100);
        sample_queue.push_back(16'd1101);

        // hold-off counter between adjustments
        load_setup(1000, 100, 300, 2, -1000, 1000, MODE_ACTIVE, -5);
        repeat (4) sample_queue.push_back(16'h0000);

        // frozen holds, but a fault sample still clears
        load_setup(1000, 100, 300, 2, -1000, 1000, MODE_FROZEN, -5);
        sample_queue.push_back(16'h0000);
        sample_queue.push_back(16'hFFFB);

        // unused mode code behaves as disabled
        load_setup(1000, 100, 300, 2, -1000, 1000, MODE_UNUSED, -5);
        sample_queue.push_back(16'h0000);

        // widest band and step, clamp at the top
        load_setup(32767, 32767, 32767, 0, -32768, 32767, MODE_ACTIVE, -32768);
        sample_queue.push_back(16'hFFFF);
        sample_queue.push_back(16'hFFFF);
        sample_queue.push_back(16'h7FFF);
        sample_queue.push_back(16'h8000);

        // zero band, clamp at the bottom
        load_setup(0, 0, 32767, 0, -32768, 32767, MODE_ACTIVE, 0);
        sample_queue.push_back(16'h7FFF);
        sample_queue.push_back(16'h7FFF);

        // floor above ceiling
        load_setup(0, 0, 100, 0, 500, -500, MODE_ACTIVE, 32767);
        sample_queue.push_back(16'h0000);
        sample_queue.push_back(16'h0001);
        sample_queue.push_back(16'hFFFF);

        for (phase = 0; phase < RandomPhases; phase++)
        begin
            r   = $urandom_range(0, 9);
            tgt = (r == 0) ? 0 : (r == 1) ? 32767 :
                  (r < 5) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
            dz  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) :
                  $urandom_range(0, 400);
            r   = $urandom_range(0, 9);
            stp = (r == 0) ? 0 : (r == 1) ? 32767 : $urandom_range(0, 2000);
            // a big hold-off never runs out, so it only goes in the last phase
            if (phase == RandomPhases - 1)
                hold = 65535;
            else if ($urandom_range(0, 5) == 0)
                hold = $urandom_range(0, 40);
            else
                hold = $urandom_range(0, 3);
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                lo = -32768;
                hi = 32767;
            end
            else if (r == 1)
            begin
                lo = $urandom_range(0, 2000);
                hi = -int'($urandom_range(0, 2000));
            end
            else
            begin
                lo = -int'($urandom_range(0, 32768));
                hi = $urandom_range(0, 32767);
            end
            r    = $urandom_range(0, 9);
            mode = (r < 7) ? MODE_ACTIVE : (r == 7) ? MODE_FROZEN :
                   (r == 8) ? MODE_DISABLED : MODE_UNUSED;
            bad  = $urandom_range(0, 65535);
            load_setup(tgt, dz, stp, hold, lo, hi, mode, bad);
            if (phase == RandomPhases - 1)
                steady_tail = 1'b1;

            for (n = 0; n < PhaseSamples; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    smp = 16'(fault_code);
                else if (r < 10)
                begin
                    case ($urandom_range(0, 3))
                        0: smp = 16'h8000;
                        1: smp = 16'h7FFF;
                        2: smp = 16'h0000;
                        default: smp = 16'hFFFF;
                    endcase
                end
                else if (r < 35)
                    smp = 16'($urandom);
                else
                begin
                    // mostly near the band so both step directions and the hold band show
                    span = band_half + 64;
                    smp  = 16'(level_set + int'($urandom_range(0, 2 * span)) - span);
                end
                sample_queue.push_back(smp);
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/dft_pkg.sv
sv/dft_update.sv
sv/deadband_step_fan_trim.sv
tb/sv/tb.sv
